// ----- src/lrupr_pkg.sv -----
// Shared types and constants for the LRU page replacement block.
package lrupr_pkg;

   // Default sizes and fixed field widths
   localparam int MAX_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 16;
   localparam int PAGE_W         = 16;
   localparam int INDEX_W        = 4;
   localparam int COUNT_W        = 32;
   localparam int CSR_W          = 5;

   localparam logic [CSR_W-1:0] FRAMES_RESET = 5'd16;

   // Broadcast command from the controller to every frame cell
   typedef struct packed {
      logic touch;    // update the frame row this cycle
      logic fill;     // target frame loads the new page
      logic age_all;  // target was empty: every valid frame ages
   } cell_cmd_type;

   // Per-cell lookup status
   typedef struct packed {
      logic valid;    // frame holds a page
      logic hit;      // searched frame holds the looked-up page
      logic empty;    // searched frame holds no page
      logic oldest;   // searched frame has the rank under scan
   } cell_sts_type;

endpackage

// ----- src/lru_page_replacement.sv -----
// Top level of the LRU page replacement block: frame cell row and controller.
//
// Each request transaction carries one page reference and yields one response.
// A hit, or a miss that finds an empty frame, passes a lookup state in which
// every frame cell compares its tag at once, then an update state in which the
// row re-ranks and the response is registered; the next request is taken in
// that update state. A miss with all searched frames full adds a rank scan
// that steps down one rank per cycle from the oldest valid rank until a
// searched frame holds it, stepping past each ignored frame (at or above
// frames_in_use) that is older than the oldest searched frame. The response
// register decouples the two sides; a held response stalls only the update
// cycle of the following transaction. No clearing pass follows reset.
module lru_page_replacement #(
   parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [lrupr_pkg::PAGE_W-1:0]  req_page_number,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_hit,
   output logic [lrupr_pkg::INDEX_W-1:0] rsp_frame_index,
   output logic                          rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_W-1:0]  rsp_evicted_page,
   output logic [lrupr_pkg::COUNT_W-1:0] rsp_fault_count,
   // configuration channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [lrupr_pkg::CSR_W-1:0]   csr_frames_in_use
);
   import lrupr_pkg::*;

   localparam int MF   = MAX_FRAMES;
   localparam int RW   = (MF > 1) ? $clog2(MF) : 1;
   localparam int IW   = RW;
   localparam int VCW  = $clog2(MF + 1);
   localparam int NW   = (VCW > CSR_W) ? VCW : CSR_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOOK = 2'd1;
   localparam logic [1:0] ST_SEEK = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [MF-1:0]        target_ff, target_in;
   logic                 miss_ff, miss_in;
   logic                 evict_ff, evict_in;
   logic [RW-1:0]        scan_ff, scan_in;
   logic [VCW-1:0]       valid_cnt_ff, valid_cnt_in;
   logic [COUNT_W-1:0]   fault_ff, fault_in;
   logic [CSR_W-1:0]     frames_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_hit_ff;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic                 rsp_ev_valid_ff;
   logic [PAGE_W-1:0]    rsp_ev_page_ff;
   logic [COUNT_W-1:0]   rsp_fault_ff;

   cell_sts_type         sts [MF];
   logic [PAGE_BITS-1:0] cell_page [MF];
   logic [RW-1:0]        cell_rank [MF];
   logic [MF-1:0]        active, hit_vec, empty_vec, oldest_vec, valid_vec;
   logic [MF-1:0]        hit_first, empty_first;
   cell_cmd_type         cmd;

   logic [NW-1:0]           n_active;
   logic [PAGE_BITS+PAGE_W-1:0] req_ext;
   logic [IW+INDEX_W-1:0]   idx_ext;
   logic [PAGE_BITS+PAGE_W-1:0] ev_ext;
   logic [VCW-1:0]          cnt_m1;
   logic [IW-1:0]           tgt_idx;
   logic [PAGE_BITS-1:0]    tgt_page;
   logic [RW-1:0]           tgt_rank;
   logic                    tgt_valid;
   logic                    out_free, apply, accept;

   // Active frame count, clamped to 1..MAX_FRAMES
   always_comb begin
      n_active = NW'(frames_ff);
      if (frames_ff == '0) begin
         n_active = NW'(1);
      end else if (NW'(frames_ff) > NW'(MF)) begin
         n_active = NW'(MF);
      end
   end

   // Frame cell row
   for (genvar i = 0; i < MF; i++) begin : g_cell
      assign active[i] = NW'(i) < n_active;

      lrupr_cell #(
         .PAGE_BITS (PAGE_BITS),
         .RANK_W    (RW)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .active      (active[i]),
         .lookup_page (page_ff),
         .scan_rank   (scan_ff),
         .old_rank    (tgt_rank),
         .sel         (target_ff[i]),
         .cmd         (cmd),
         .sts         (sts[i]),
         .page_q      (cell_page[i]),
         .rank_q      (cell_rank[i])
      );

      assign hit_vec[i]    = sts[i].hit;
      assign empty_vec[i]  = sts[i].empty;
      assign oldest_vec[i] = sts[i].oldest;
      assign valid_vec[i]  = sts[i].valid;
   end

   // Lowest-numbered match: isolate the least significant set bit
   assign hit_first   = hit_vec & (~hit_vec + MF'(1));
   assign empty_first = empty_vec & (~empty_vec + MF'(1));

   // Read out the target frame through its one-hot select
   always_comb begin
      tgt_idx   = '0;
      tgt_page  = '0;
      tgt_rank  = '0;
      tgt_valid = 1'b0;
      for (int i = 0; i < MF; i++) begin
         if (target_ff[i]) begin
            tgt_idx   = tgt_idx | IW'(i);
            tgt_page  = tgt_page | cell_page[i];
            tgt_rank  = tgt_rank | cell_rank[i];
            tgt_valid = tgt_valid | valid_vec[i];
         end
      end
   end

   // Handshakes
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign apply     = (state_ff == ST_DONE) && out_free;
   assign req_stall = !((state_ff == ST_IDLE) || apply);
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign cmd.touch   = apply;
   assign cmd.fill    = miss_ff;
   assign cmd.age_all = !tgt_valid;

   assign req_ext = {{PAGE_BITS{1'b0}}, req_page_number};
   assign idx_ext = {{INDEX_W{1'b0}}, tgt_idx};
   assign ev_ext  = {{PAGE_W{1'b0}}, tgt_page};
   assign cnt_m1  = valid_cnt_ff - VCW'(1);

   // Controller
   always_comb begin
      state_in     = state_ff;
      page_in      = page_ff;
      target_in    = target_ff;
      miss_in      = miss_ff;
      evict_in     = evict_ff;
      scan_in      = scan_ff;
      valid_cnt_in = valid_cnt_ff;
      fault_in     = fault_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (accept) begin
         page_in = req_ext[PAGE_BITS-1:0];
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (|hit_vec) begin
               target_in = hit_first;
               miss_in   = 1'b0;
               evict_in  = 1'b0;
               state_in  = ST_DONE;
            end else if (|empty_vec) begin
               target_in = empty_first;
               miss_in   = 1'b1;
               evict_in  = 1'b0;
               state_in  = ST_DONE;
            end else begin
               scan_in  = cnt_m1[RW-1:0];
               miss_in  = 1'b1;
               evict_in = 1'b1;
               state_in = ST_SEEK;
            end
         end
         ST_SEEK: begin
            // Step down until a searched frame holds the scanned rank
            if (|oldest_vec) begin
               target_in = oldest_vec;
               state_in  = ST_DONE;
            end else begin
               scan_in = scan_ff - RW'(1);
            end
         end
         ST_DONE: begin
            if (apply) begin
               rsp_valid_in = 1'b1;
               if (!tgt_valid) begin
                  valid_cnt_in = valid_cnt_ff + VCW'(1);
               end
               if (miss_ff && (fault_ff != '1)) begin
                  fault_in = fault_ff + COUNT_W'(1);
               end
               state_in = accept ? ST_LOOK : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_cnt_ff <= '0;
         fault_ff     <= '0;
         frames_ff    <= FRAMES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_cnt_ff <= valid_cnt_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            frames_ff <= csr_frames_in_use;
         end
      end
   end

   // Datapath and response registers
   always_ff @(posedge clock) begin
      page_ff   <= page_in;
      target_ff <= target_in;
      miss_ff   <= miss_in;
      evict_ff  <= evict_in;
      scan_ff   <= scan_in;
      if (apply) begin
         rsp_hit_ff      <= !miss_ff;
         rsp_index_ff    <= idx_ext[INDEX_W-1:0];
         rsp_ev_valid_ff <= evict_ff;
         rsp_ev_page_ff  <= evict_ff ? ev_ext[PAGE_W-1:0] : '0;
         rsp_fault_ff    <= fault_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_index_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_fault_ff;

`ifndef SYNTHESIS
   // The update cycle always works on exactly one frame
   a_target_onehot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> $onehot(target_ff))
      else $error("update without a single target frame");

   // Valid frames hold distinct ranks, so the scan matches at most one
   a_scan_unique: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEEK) |-> $onehot0(oldest_vec))
      else $error("rank scan matched more than one frame");

   // Valid count tracks the valid bits of the row
   a_valid_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ($countones(valid_vec) == int'(valid_cnt_ff)))
      else $error("valid count out of step with frame row");

   // Hits leave the fault count alone
   a_hit_no_fault: assert property (@(posedge clock) disable iff (reset)
      (apply && !miss_ff) |=> $stable(fault_ff))
      else $error("fault counted on a hit");

   // An eviction is never reported for a hit
   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ev_valid_ff) |-> !rsp_hit_ff)
      else $error("eviction reported on a hit");
`endif

endmodule

// ----- src/lrupr_cell.sv -----
// One frame cell: page tag, valid bit and recency rank with local compares.
module lrupr_cell #(
   parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF,
   parameter int RANK_W    = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       active,
   input  logic [PAGE_BITS-1:0]       lookup_page,
   input  logic [RANK_W-1:0]          scan_rank,
   input  logic [RANK_W-1:0]          old_rank,
   input  logic                       sel,
   input  lrupr_pkg::cell_cmd_type    cmd,
   output lrupr_pkg::cell_sts_type    sts,
   output logic [PAGE_BITS-1:0]       page_q,
   output logic [RANK_W-1:0]          rank_q
);
   import lrupr_pkg::*;

   logic                 valid_ff, valid_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic [RANK_W-1:0]    rank_ff, rank_in;

   // Local compares, all cells in parallel
   always_comb begin
      sts.valid  = valid_ff;
      sts.hit    = active && valid_ff && (page_ff == lookup_page);
      sts.empty  = active && !valid_ff;
      sts.oldest = active && valid_ff && (rank_ff == scan_rank);
   end

   assign page_q = page_ff;
   assign rank_q = rank_ff;

   // Update: target becomes newest; younger frames age, all if it was empty
   always_comb begin
      valid_in = valid_ff;
      page_in  = page_ff;
      rank_in  = rank_ff;
      if (cmd.touch) begin
         if (sel) begin
            valid_in = 1'b1;
            rank_in  = '0;
            if (cmd.fill) begin
               page_in = lookup_page;
            end
         end else if (valid_ff && (cmd.age_all || (rank_ff < old_rank))) begin
            rank_in = rank_ff + RANK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      page_ff <= page_in;
      rank_ff <= rank_in;
   end

endmodule
